[hdl/clock_menu_time_setter_defines.svh]
// assertion macros shared by the clock menu checker
`ifndef CLOCK_MENU_TIME_SETTER_DEFINES_SVH
`define CLOCK_MENU_TIME_SETTER_DEFINES_SVH

// concurrent check, quiet while reset is held
`define CMTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs through reset
`define CMTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/cmts_pkg.sv]
// types, codes and lookup functions for the clock menu time setter
package cmts_pkg;

    // key codes
    localparam logic [2:0] KEY_NONE   = 3'd0;
    localparam logic [2:0] KEY_MENU   = 3'd1;
    localparam logic [2:0] KEY_SELECT = 3'd2;
    localparam logic [2:0] KEY_UP     = 3'd3;
    localparam logic [2:0] KEY_DOWN   = 3'd4;

    // menu screens
    localparam logic [2:0] SCR_ID      = 3'd0;
    localparam logic [2:0] SCR_SHOW_HM = 3'd1;
    localparam logic [2:0] SCR_SHOW_MD = 3'd2;
    localparam logic [2:0] SCR_SET_HM  = 3'd3;
    localparam logic [2:0] SCR_SET_MD  = 3'd4;

    // field selector codes
    localparam logic [2:0] FLD_MONTH  = 3'd1;
    localparam logic [2:0] FLD_DAY    = 3'd2;
    localparam logic [2:0] FLD_HOUR   = 3'd3;
    localparam logic [2:0] FLD_MINUTE = 3'd4;

    // fixed id screen "1780" and decimal point
    localparam logic [7:0] SEG_ID0 = 8'h06;
    localparam logic [7:0] SEG_ID1 = 8'h07;
    localparam logic [7:0] SEG_ID2 = 8'h7f;
    localparam logic [7:0] SEG_ID3 = 8'h3f;
    localparam logic [7:0] SEG_DP  = 8'h80;

    typedef struct packed {
        logic [2:0] key;
        logic [6:0] rtc_year;
        logic [3:0] rtc_month;
        logic [4:0] rtc_day;
        logic [4:0] rtc_hour;
        logic [5:0] rtc_minute;
    } t_in_word;

    typedef struct packed {
        logic [7:0] seg_digit0;
        logic [7:0] seg_digit1;
        logic [7:0] seg_digit2;
        logic [7:0] seg_digit3;
        logic       write_rtc;
        logic [6:0] set_year;
        logic [3:0] set_month;
        logic [4:0] set_day;
        logic [4:0] set_hour;
        logic [5:0] set_minute;
    } t_out_word;

    // seven-segment code of a hex digit
    function automatic logic [7:0] seg_code(logic [3:0] v);
        logic [7:0] c;
        unique case (v)
            4'h0: c = 8'h3f;
            4'h1: c = 8'h06;
            4'h2: c = 8'h5b;
            4'h3: c = 8'h4f;
            4'h4: c = 8'h66;
            4'h5: c = 8'h6d;
            4'h6: c = 8'h7d;
            4'h7: c = 8'h07;
            4'h8: c = 8'h7f;
            4'h9: c = 8'h6f;
            4'ha: c = 8'h77;
            4'hb: c = 8'h7c;
            4'hc: c = 8'h39;
            4'hd: c = 8'h5e;
            4'he: c = 8'h79;
            4'hf: c = 8'h71;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // tens digit of a value below 64, by reciprocal multiply
    function automatic logic [3:0] tens_of(logic [5:0] v);
        logic [10:0] p;
        p = {5'b0, v} * 11'd26;
        return {1'b0, p[10:8]};
    endfunction

    // units digit of a value below 64
    function automatic logic [3:0] units_of(logic [5:0] v);
        logic [5:0] r;
        r = v - ({2'b0, tens_of(v)} * 6'd10);
        return r[3:0];
    endfunction

    // days in a month, zero for a month code outside 1..12
    function automatic logic [4:0] month_len(logic signed [7:0] m, logic [6:0] y);
        logic [4:0] n;
        if (m == 8'sd1 || m == 8'sd3 || m == 8'sd5 || m == 8'sd7 ||
            m == 8'sd8 || m == 8'sd10 || m == 8'sd12) begin
            n = 5'd31;
        end else if (m == 8'sd4 || m == 8'sd6 || m == 8'sd9 || m == 8'sd11) begin
            n = 5'd30;
        end else if (m == 8'sd2) begin
            n = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
        end else begin
            n = 5'd0;
        end
        return n;
    endfunction

endpackage

[hdl/cmts_if.sv]
// valid/ready channels for input and result words
interface cmts_in_if;
    import cmts_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cmts_out_if;
    import cmts_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/clock_menu_time_setter.sv]
// clock menu and time setter with four-digit seven-segment output
// from input accept to result valid a word passes the input reg, then the result reg
// throughput: one word per cycle while the result is not stalled; menu state updates as a word leaves the input reg
// a stalled result holds while the input reg still takes one more word
// synchronous active-low reset clears both valid flags, menu screen (0), selector (1)
// held time registers have no reset and are loaded on the display screens
module clock_menu_time_setter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cmts_in_if.sink           i_in,
    cmts_out_if.source        o_out
);
    import cmts_pkg::*;

    logic       r_in_valid;
    t_in_word   r_in;
    logic       r_out_valid;
    t_out_word  r_out;

    logic [2:0] r_screen, n_screen;
    logic [2:0] r_field, n_field;
    logic [6:0] r_year, n_year;
    logic [3:0] r_month, n_month;
    logic [4:0] r_day, n_day;
    logic [4:0] r_hour, n_hour;
    logic [5:0] r_minute, n_minute;

    t_out_word  n_out;
    logic       w_adv;
    logic       w_in_acc;
    logic       w_setting;

    // handshake
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_acc) begin
            r_in <= i_in.data;
        end
    end

    // menu screen step
    always_comb begin
        n_screen = (r_screen > SCR_SET_MD) ? SCR_ID : r_screen;
        if (r_in.key == KEY_MENU) begin
            n_screen = (n_screen == SCR_SET_MD) ? SCR_ID : n_screen + 3'd1;
        end
        w_setting = (n_screen == SCR_SET_HM) || (n_screen == SCR_SET_MD);
    end

    // held time load or edit
    always_comb begin
        logic signed [7:0] mo, dy, hr, mi, delta;
        logic [4:0]        len;
        logic              up;

        up    = (r_in.key == KEY_UP);
        delta = up ? 8'sd1 : -8'sd1;
        mo    = signed'({4'b0, r_month});
        dy    = signed'({3'b0, r_day});
        hr    = signed'({3'b0, r_hour});
        mi    = signed'({2'b0, r_minute});
        len   = 5'd0;

        n_field  = r_field;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;

        if (!w_setting) begin
            n_year   = r_in.rtc_year;
            n_month  = r_in.rtc_month;
            n_day    = r_in.rtc_day;
            n_hour   = r_in.rtc_hour;
            n_minute = r_in.rtc_minute;
        end else if (r_in.key == KEY_SELECT) begin
            n_field = r_field + 3'd1;
            if (n_field >= 3'd5) begin
                n_field = FLD_MONTH;
            end
        end else if (r_in.key == KEY_UP || r_in.key == KEY_DOWN) begin
            unique case (r_field)
                FLD_MONTH:  mo = mo + delta;
                FLD_DAY:    dy = dy + delta;
                FLD_HOUR:   hr = hr + delta;
                FLD_MINUTE: mi = mi + delta;
                default:    ;
            endcase
            if (up) begin
                if (mo > 8'sd12) begin
                    mo = 8'sd1;
                end
                len = month_len(mo, r_year);
                if (len != 5'd0 && dy > signed'({3'b0, len})) begin
                    dy = 8'sd1;
                end
                if (hr > 8'sd23) begin
                    hr = 8'sd0;
                end
                if (mi > 8'sd59) begin
                    mi = 8'sd0;
                end
            end else begin
                if (mo < 8'sd1) begin
                    mo = 8'sd12;
                end
                len = month_len(mo, r_year);
                if (len != 5'd0) begin
                    if (dy < 8'sd1) begin
                        dy = signed'({3'b0, len});
                    end
                    if (dy > signed'({3'b0, len})) begin
                        dy = 8'sd1;
                    end
                end
                if (hr < 8'sd0) begin
                    hr = 8'sd23;
                end
                if (mi < 8'sd0) begin
                    mi = 8'sd59;
                end
            end
            n_month  = mo[3:0];
            n_day    = dy[4:0];
            n_hour   = hr[4:0];
            n_minute = mi[5:0];
        end
    end

    // result word: write request from old time, digits from new time
    always_comb begin
        logic [5:0] hi, lo;

        if (n_screen == SCR_SHOW_HM || n_screen == SCR_SET_HM) begin
            hi = {1'b0, n_hour};
            lo = n_minute;
        end else begin
            hi = {2'b0, n_month};
            lo = {1'b0, n_day};
        end

        n_out.write_rtc  = w_setting;
        n_out.set_year   = w_setting ? r_year   : 7'd0;
        n_out.set_month  = w_setting ? r_month  : 4'd0;
        n_out.set_day    = w_setting ? r_day    : 5'd0;
        n_out.set_hour   = w_setting ? r_hour   : 5'd0;
        n_out.set_minute = w_setting ? r_minute : 6'd0;

        if (n_screen == SCR_ID) begin
            n_out.seg_digit0 = SEG_ID0;
            n_out.seg_digit1 = SEG_ID1;
            n_out.seg_digit2 = SEG_ID2;
            n_out.seg_digit3 = SEG_ID3;
        end else begin
            n_out.seg_digit0 = seg_code(tens_of(hi));
            n_out.seg_digit1 = seg_code(units_of(hi)) | SEG_DP;
            n_out.seg_digit2 = seg_code(tens_of(lo));
            n_out.seg_digit3 = seg_code(units_of(lo));
        end
    end

    // menu state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen <= SCR_ID;
            r_field  <= FLD_MONTH;
        end else if (w_adv) begin
            r_screen <= n_screen;
            r_field  <= n_field;
        end
    end

    // held time
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

endmodule

[hdl/cmts_checker.sv]
// port-level checks for the clock menu time setter, bound to the top level
`include "clock_menu_time_setter_defines.svh"

module cmts_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input cmts_pkg::t_out_word i_out_data
);
    import cmts_pkg::*;

    // no stray result right out of reset
    `CMTS_ASSERT_ALWAYS(a_reset_quiet, i_clk, $rose(i_rst_n) |-> !i_out_valid, "result valid after reset")

    // a stalled word holds its place and value
    `CMTS_ASSERT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data), "stalled word changed")

    // set fields are zero without a write request
    `CMTS_ASSERT(a_set_zero, i_clk, i_rst_n, i_out_valid && !i_out_data.write_rtc |-> i_out_data.set_year == 7'd0 && i_out_data.set_month == 4'd0 && i_out_data.set_day == 5'd0 && i_out_data.set_hour == 5'd0 && i_out_data.set_minute == 6'd0, "set fields not cleared")

    // set screens always light the decimal point
    `CMTS_ASSERT(a_set_dp, i_clk, i_rst_n, i_out_valid && i_out_data.write_rtc |-> i_out_data.seg_digit1[7], "decimal point dark on set screen")

endmodule

bind clock_menu_time_setter cmts_checker u_cmts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
